FILE: design/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types and helpers for the Catmull-Rom curve sampler
// Payload structs, the sequencer state type, the control bundle and the
// fixed-point helpers used by the datapath.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int MAX_SAMPLES_DEF = 64;  // upper limit on samples per segment
  localparam int CFG_W           = 7;   // width of samples_per_segment
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam int PT_W            = 10;  // control point coordinate width
  localparam int T_W             = 16;  // t is unsigned 0.16
  localparam int Q_W             = T_W + 1;  // quotient of 2^16 / n
  localparam int OUT_W           = 16;  // signed 12.4 sample
  localparam int ACC_W           = 66;  // Horner accumulator, scale 2^48
  localparam int OP_W            = 32;  // multiplier operand width
  localparam int PROD_W          = OP_W + T_W + 1;
  localparam int HI_SHIFT        = 24;  // split point of the last Horner step
  localparam int RND_SHIFT       = 45;  // 2^48 scale with factor 0.5 to 4 fraction bits

  typedef struct packed {
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
    logic            new_curve;
  } crs_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_x;
    logic signed [OUT_W-1:0] sample_y;
    logic                    last_sample;
  } crs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_EMIT
  } crs_state_t;

  // Horner phases of one coordinate.
  typedef enum logic [1:0] {
    PH_A  = 2'd0,
    PH_B  = 2'd1,
    PH_HI = 2'd2,
    PH_LO = 2'd3
  } crs_phase_t;

  typedef struct packed {
    logic       mac_en;
    crs_phase_t phase;
    logic       coord;      // 0: x, 1: y
    logic       cap_x;
    logic       div_start;
    logic       t_step;
    logic       out_load;
    logic       last;
  } crs_ctl_t;

  typedef struct packed {
    logic signed [13:0] a;
    logic signed [13:0] b;
    logic signed [10:0] c;
    logic signed [11:0] d;
  } crs_coef_t;

  // Cubic coefficients of one coordinate, scaled by two.
  function automatic crs_coef_t crs_coef(input logic [PT_W-1:0] p0,
                                         input logic [PT_W-1:0] p1,
                                         input logic [PT_W-1:0] p2,
                                         input logic [PT_W-1:0] p3);
    logic signed [13:0] e0;
    logic signed [13:0] e1;
    logic signed [13:0] e2;
    logic signed [13:0] e3;
    logic signed [13:0] cw;
    crs_coef_t          r;
    e0 = $signed({4'b0, p0});
    e1 = $signed({4'b0, p1});
    e2 = $signed({4'b0, p2});
    e3 = $signed({4'b0, p3});
    cw = e2 - e0;
    r.a = e3 - e0 + 14'sd3 * e1 - 14'sd3 * e2;
    r.b = 14'sd2 * e0 - 14'sd5 * e1 + 14'sd4 * e2 - e3;
    r.c = cw[10:0];
    r.d = $signed({1'b0, p1, 1'b0});
    return r;
  endfunction

  // Round half up to 4 fraction bits and saturate to 16 bits.
  function automatic logic signed [OUT_W-1:0] crs_round_sat(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0]           biased;
    logic signed [ACC_W-RND_SHIFT-1:0] q;
    logic signed [OUT_W-1:0]           r;
    biased = v + (ACC_W'(1) <<< (RND_SHIFT - 1));
    q = biased[ACC_W-1:RND_SHIFT];
    if (q > (ACC_W-RND_SHIFT)'(32767)) begin
      r = 16'sh7FFF;
    end else if (q < -(ACC_W-RND_SHIFT)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/crs_mac.sv
// ----------------------------------------------------------------------------
// crs_mac: shared multiply-add unit
// One signed multiply by t and one wide add per cycle while en is high,
// stepping through the Horner form of one coordinate in four phases.
// ----------------------------------------------------------------------------
module crs_mac (
  input  logic                                clk,
  input  logic                                en,
  input  crs_pkg::crs_phase_t                 phase,
  input  crs_pkg::crs_coef_t                  coef,
  input  logic [crs_pkg::T_W-1:0]             t,
  output logic signed [crs_pkg::ACC_W-1:0]    acc
);

  logic signed [crs_pkg::ACC_W-1:0]  acc_r;
  logic signed [crs_pkg::ACC_W-1:0]  acc_nxt;
  logic [crs_pkg::HI_SHIFT-1:0]      lo_r;
  logic signed [crs_pkg::OP_W-1:0]   op;
  logic signed [crs_pkg::ACC_W-1:0]  addend;
  logic                              shift_hi;
  logic signed [crs_pkg::PROD_W-1:0] prod;
  logic signed [crs_pkg::ACC_W-1:0]  prod_ext;

  // Operand and addend selection per Horner phase. The last step is split
  // into a high and a low half so the multiplier stays 32 bits wide.
  always_comb begin
    op       = '0;
    addend   = '0;
    shift_hi = 1'b0;
    unique case (phase)
      crs_pkg::PH_A: begin
        op     = crs_pkg::OP_W'(coef.a);
        addend = crs_pkg::ACC_W'(coef.b) <<< 16;
      end
      crs_pkg::PH_B: begin
        op     = acc_r[crs_pkg::OP_W-1:0];
        addend = crs_pkg::ACC_W'(coef.c) <<< 32;
      end
      crs_pkg::PH_HI: begin
        op       = crs_pkg::OP_W'($signed(acc_r[2*crs_pkg::HI_SHIFT-1:crs_pkg::HI_SHIFT]));
        addend   = crs_pkg::ACC_W'(coef.d) <<< 48;
        shift_hi = 1'b1;
      end
      crs_pkg::PH_LO: begin
        op     = $signed({{(crs_pkg::OP_W-crs_pkg::HI_SHIFT){1'b0}}, lo_r});
        addend = acc_r;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  assign prod     = op * $signed({1'b0, t});
  assign prod_ext = crs_pkg::ACC_W'(prod);
  assign acc_nxt  = (shift_hi ? (prod_ext <<< crs_pkg::HI_SHIFT) : prod_ext) + addend;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      if (phase == crs_pkg::PH_HI) begin
        lo_r <= acc_r[crs_pkg::HI_SHIFT-1:0];
      end
    end
  end

  assign acc = acc_r;

endmodule

FILE: design/crs_tgen.sv
// ----------------------------------------------------------------------------
// crs_tgen: sample position generator
// Divides 2^16 by the sample count bit by bit once per segment, then steps
// t = floor(j * 2^16 / n) with a quotient add and a remainder correction.
// ----------------------------------------------------------------------------
module crs_tgen #(
  parameter int MAX_SAMPLES = crs_pkg::MAX_SAMPLES_DEF,
  localparam int NW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    step,
  input  logic [NW-1:0]           n,
  output logic [crs_pkg::T_W-1:0] t,
  output logic                    busy
);

  localparam int BW = $clog2(crs_pkg::Q_W);

  logic                    busy_r;
  logic [BW-1:0]           bcnt_r;
  logic [crs_pkg::Q_W-1:0] q0_r;
  logic [NW-1:0]           r0_r;
  logic [NW-1:0]           frac_r;
  logic [crs_pkg::T_W-1:0] t_r;

  logic [NW:0]             div_sh;
  logic                    div_bit;
  logic [NW:0]             frac_sum;
  logic                    frac_wrap;

  assign div_sh    = {r0_r, (bcnt_r == BW'(crs_pkg::T_W))};
  assign div_bit   = (div_sh >= {1'b0, n});
  assign frac_sum  = {1'b0, frac_r} + {1'b0, r0_r};
  assign frac_wrap = (frac_sum >= {1'b0, n});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (bcnt_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bcnt_r <= BW'(crs_pkg::T_W);
      r0_r   <= '0;
      q0_r   <= '0;
      t_r    <= '0;
      frac_r <= '0;
    end else if (busy_r) begin
      bcnt_r <= bcnt_r - 1'b1;
      q0_r   <= {q0_r[crs_pkg::Q_W-2:0], div_bit};
      r0_r   <= div_bit ? NW'(div_sh - {1'b0, n}) : div_sh[NW-1:0];
    end else if (step) begin
      t_r    <= t_r + q0_r[crs_pkg::T_W-1:0] + crs_pkg::T_W'(frac_wrap);
      frac_r <= frac_wrap ? NW'(frac_sum - {1'b0, n}) : frac_sum[NW-1:0];
    end
  end

  assign t    = t_r;
  assign busy = busy_r;

endmodule

FILE: design/crs_seq.sv
// ----------------------------------------------------------------------------
// crs_seq: sequencer of the curve sampler
// Runs the division, the eight multiply-add phases of each sample and the
// hand-off of each sample to the output register.
// ----------------------------------------------------------------------------
module crs_seq #(
  parameter int MAX_SAMPLES = crs_pkg::MAX_SAMPLES_DEF,
  localparam int NW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              seg_go,
  input  logic              div_busy,
  input  logic              out_free,
  input  logic [NW-1:0]     n,
  output logic              in_ready,
  output crs_pkg::crs_ctl_t ctl
);

  crs_pkg::crs_state_t state_r, state_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [NW-1:0]       j_r, j_nxt;
  logic                last;

  assign last = (j_r == n - 1'b1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crs_pkg::ST_IDLE: begin
        if (in_valid && seg_go) begin
          state_nxt = crs_pkg::ST_DIV;
        end
      end
      crs_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = crs_pkg::ST_EVAL;
        end
      end
      crs_pkg::ST_EVAL: begin
        if (cnt_r == 3'b111) begin
          state_nxt = crs_pkg::ST_EMIT;
        end
      end
      crs_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = last ? crs_pkg::ST_IDLE : crs_pkg::ST_EVAL;
        end
      end
      default: begin
        state_nxt = crs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state_r == crs_pkg::ST_IDLE);
    ctl.mac_en    = (state_r == crs_pkg::ST_EVAL);
    ctl.phase     = crs_pkg::crs_phase_t'(cnt_r[1:0]);
    ctl.coord     = cnt_r[2];
    ctl.cap_x     = (state_r == crs_pkg::ST_EVAL) && (cnt_r == 3'b100);
    ctl.div_start = (state_r == crs_pkg::ST_IDLE) && in_valid && seg_go;
    ctl.out_load  = (state_r == crs_pkg::ST_EMIT) && out_free;
    ctl.t_step    = ctl.out_load && !last;
    ctl.last      = last;
  end

  always_comb begin
    cnt_nxt = (state_r == crs_pkg::ST_EVAL) ? cnt_r + 1'b1 : cnt_r;
    j_nxt   = j_r;
    if (ctl.div_start) begin
      j_nxt = '0;
    end else if (ctl.t_step) begin
      j_nxt = j_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crs_pkg::ST_IDLE;
      cnt_r   <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

FILE: design/catmull_rom_curve_sampler_top.sv
// ----------------------------------------------------------------------------
// catmull_rom_curve_sampler_top: uniform 2D Catmull-Rom curve sampler
// Takes control points and emits evenly spaced samples of each closed
// segment in signed 12.4 fixed point.
// ----------------------------------------------------------------------------
// Usage:
// Control points arrive on the in_ channel as valid/ready transactions. A
// point with new_curve set discards the held points and starts a new curve.
// The first three points of a curve are only stored in the point history.
// Every later point closes a segment and produces N result transactions on
// the out_ channel, N being samples_per_segment (0 acts as 1, values above
// MAX_SAMPLES act as MAX_SAMPLES); the last one carries last_sample.
// A closing point starts a bit-serial division of 2^16 by N; then, for each
// sample, the one shared multiply-add unit runs four Horner phases for x and
// four for y, and the sample is handed to the output register. in_ready is
// low for the whole segment. The output register lets the next sample be
// computed while the previous one waits; a stalled receiver holds the
// sequencer in its hand-off state. The cfg_ port writes samples_per_segment
// with no wait; the user must write it only while the block is idle, which
// the block itself does not enforce. Reset sets the count to 64 and empties
// the point history; there is no clearing pass.
// ----------------------------------------------------------------------------
module catmull_rom_curve_sampler_top #(
  parameter int MAX_SAMPLES = crs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  crs_pkg::crs_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output crs_pkg::crs_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [crs_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_SAMPLES + 1);

  // Configuration register.
  logic [crs_pkg::CFG_W-1:0] samples_r;
  logic [NW-1:0]             n_eff;
  logic [NW-1:0]             n_r;

  // Point history: the three held points and the point closing the segment.
  logic [crs_pkg::PT_W-1:0]  held_x_r [3];
  logic [crs_pkg::PT_W-1:0]  held_y_r [3];
  logic [1:0]                count_r;
  logic [crs_pkg::PT_W-1:0]  cur_x_r;
  logic [crs_pkg::PT_W-1:0]  cur_y_r;

  logic                      in_accept;
  logic                      seg_go;
  logic [1:0]                slot;
  logic                      shift_win;

  crs_pkg::crs_ctl_t         ctl;
  crs_pkg::crs_coef_t        coef;
  logic [crs_pkg::T_W-1:0]   t;
  logic                      div_busy;
  logic signed [crs_pkg::ACC_W-1:0] acc;

  logic signed [crs_pkg::OUT_W-1:0] sx_r;
  logic                      out_valid_r;
  crs_pkg::crs_out_t         out_data_r;
  logic                      out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= crs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      samples_r <= cfg_wdata;
    end
  end

  // A zero count acts as one sample, anything above the limit as the limit.
  always_comb begin
    if (samples_r == '0) begin
      n_eff = NW'(1);
    end else if (samples_r > crs_pkg::CFG_W'(MAX_SAMPLES)) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = samples_r[NW-1:0];
    end
  end

  // A point closes a segment only when three points of the same curve are
  // already held; otherwise it goes into the next free slot (slot 0 on new_curve).
  assign in_accept = in_valid && in_ready;
  assign slot      = in_data.new_curve ? 2'd0 : count_r;
  assign seg_go    = !in_data.new_curve && (count_r == 2'd3);
  assign shift_win = ctl.out_load && ctl.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_accept && !seg_go) begin
      count_r <= slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && !seg_go) begin
      held_x_r[slot] <= in_data.point_x;
      held_y_r[slot] <= in_data.point_y;
    end else if (shift_win) begin
      held_x_r[0] <= held_x_r[1];
      held_y_r[0] <= held_y_r[1];
      held_x_r[1] <= held_x_r[2];
      held_y_r[1] <= held_y_r[2];
      held_x_r[2] <= cur_x_r;
      held_y_r[2] <= cur_y_r;
    end
    if (in_accept && seg_go) begin
      cur_x_r <= in_data.point_x;
      cur_y_r <= in_data.point_y;
      n_r     <= n_eff;
    end
  end

  // Coefficients of the coordinate the multiply-add unit is working on.
  assign coef = ctl.coord ?
                crs_pkg::crs_coef(held_y_r[0], held_y_r[1], held_y_r[2], cur_y_r) :
                crs_pkg::crs_coef(held_x_r[0], held_x_r[1], held_x_r[2], cur_x_r);

  crs_seq #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .seg_go   (seg_go),
    .div_busy (div_busy),
    .out_free (out_free),
    .n        (n_r),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // The count is taken from n_eff at the start, since n_r loads on the
  // same edge as the division starts.
  crs_tgen #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_tgen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .step  (ctl.t_step),
    .n     (ctl.div_start ? n_eff : n_r),
    .t     (t),
    .busy  (div_busy)
  );

  crs_mac u_mac (
    .clk   (clk),
    .en    (ctl.mac_en),
    .phase (ctl.phase),
    .coef  (coef),
    .t     (t),
    .acc   (acc)
  );

  // The x result is picked up in the first y phase, before it is overwritten.
  always_ff @(posedge clk) begin
    if (ctl.cap_x) begin
      sx_r <= crs_pkg::crs_round_sat(acc);
    end
  end

  // Output register: a new sample goes in when it is empty or being taken.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.sample_x    <= sx_r;
      out_data_r.sample_y    <= crs_pkg::crs_round_sat(acc);
      out_data_r.last_sample <= ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A closing point must drop in_ready until its segment is done.
  a_busy_after_seg: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && seg_go |=> !in_ready)
    else $error("in_ready stayed high after a segment started");

  // The final sample of a segment returns the block to accepting points.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    shift_win |=> in_ready)
    else $error("block not ready after the last sample");

  // Evaluation only ever runs with a full point history.
  a_eval_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mac_en |-> (count_r == 2'd3))
    else $error("evaluation with fewer than three held points");

  // A sample is never loaded over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !ctl.out_load)
    else $error("output register overwritten while stalled");

endmodule

FILE: bench/crs_sample_checker.sv
// ----------------------------------------------------------------------------
// crs_sample_checker: scoreboard for the Catmull-Rom curve sampler
// Watches the point, sample and count-register ports, keeps its own copy of
// the point history and the sample count, computes every curve sample that an
// accepted point should produce and compares the sample transactions with
// them in order.
// ----------------------------------------------------------------------------
module crs_sample_checker #(
  parameter int MAX_SAMPLES = crs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  crs_pkg::crs_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  crs_pkg::crs_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [crs_pkg::CFG_W-1:0] cfg_wdata,
  output int                        pending,
  output int                        mismatches,
  output int                        points_seen,
  output int                        samples_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [crs_pkg::CFG_W-1:0] seg_samples;
  logic [crs_pkg::PT_W-1:0]  hist_x [3];
  logic [crs_pkg::PT_W-1:0]  hist_y [3];
  int                        hist_len;
  crs_pkg::crs_out_t         expected_samples [$];

  // One coordinate of the segment at t (unsigned 0.16), in signed 12.4.
  // The cubic is summed exactly at scale 2^48, then rounded half up.
  function automatic logic signed [crs_pkg::OUT_W-1:0] spline_coord(
      input logic [crs_pkg::PT_W-1:0] p0, input logic [crs_pkg::PT_W-1:0] p1,
      input logic [crs_pkg::PT_W-1:0] p2, input logic [crs_pkg::PT_W-1:0] p3,
      input longint t);
    longint e0, e1, e2, e3;
    longint a, b, c, d, t2, t3, acc, q;
    e0 = p0;
    e1 = p1;
    e2 = p2;
    e3 = p3;
    a = -e0 + 3 * e1 - 3 * e2 + e3;
    b = 2 * e0 - 5 * e1 + 4 * e2 - e3;
    c = e2 - e0;
    d = 2 * e1;
    t2 = t * t;
    t3 = t2 * t;
    acc = a * t3 + b * t2 * (longint'(1) << 16) + c * t * (longint'(1) << 32)
        + d * (longint'(1) << 48);
    q = (acc + (longint'(1) << 44)) >>> 45;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return crs_pkg::OUT_W'(q);
  endfunction

  // Take one control point into the history; a point that closes a segment
  // queues all of that segment's samples.
  task automatic absorb_point(input crs_pkg::crs_in_t pt);
    int                n;
    longint            t;
    crs_pkg::crs_out_t s;
    if (pt.new_curve) hist_len = 0;
    if (hist_len < 3) begin
      hist_x[hist_len] = pt.point_x;
      hist_y[hist_len] = pt.point_y;
      hist_len++;
    end else begin
      n = seg_samples;
      if (n < 1) n = 1;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      for (int j = 0; j < n; j++) begin
        t = (j << 16) / n;
        s.sample_x    = spline_coord(hist_x[0], hist_x[1], hist_x[2], pt.point_x, t);
        s.sample_y    = spline_coord(hist_y[0], hist_y[1], hist_y[2], pt.point_y, t);
        s.last_sample = (j == n - 1);
        expected_samples = {expected_samples, s};
      end
      hist_x[0] = hist_x[1];
      hist_y[0] = hist_y[1];
      hist_x[1] = hist_x[2];
      hist_y[1] = hist_y[2];
      hist_x[2] = pt.point_x;
      hist_y[2] = pt.point_y;
    end
  endtask

  initial begin
    mismatches   = 0;
    points_seen  = 0;
    samples_seen = 0;
  end

  always @(posedge clk) begin : monitor
    crs_pkg::crs_out_t want;
    if (!rst_n) begin
      seg_samples = crs_pkg::CFG_RESET;
      hist_len    = 0;
      expected_samples.delete();
    end else begin
      // Samples leaving now were queued by earlier points, so check them
      // before this edge's point adds its own.
      if (out_valid && out_ready) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          $error("unexpected sample: x=%0d y=%0d last=%0b",
                 out_data.sample_x, out_data.sample_y, out_data.last_sample);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data.sample_x !== want.sample_x) begin
            $error("sample_x: expected %0d, got %0d", want.sample_x, out_data.sample_x);
            mismatches++;
          end
          if (out_data.sample_y !== want.sample_y) begin
            $error("sample_y: expected %0d, got %0d", want.sample_y, out_data.sample_y);
            mismatches++;
          end
          if (out_data.last_sample !== want.last_sample) begin
            $error("last_sample: expected %0b, got %0b",
                   want.last_sample, out_data.last_sample);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        points_seen++;
        absorb_point(in_data);
      end
      // A count written on this edge applies from the next point on.
      if (cfg_we) seg_samples = cfg_wdata;
    end
    pending <= expected_samples.size();
  end

endmodule

FILE: bench/tb_catmull_rom_curve_sampler_top.sv
// ----------------------------------------------------------------------------
// tb_catmull_rom_curve_sampler_top: regression bench for the curve sampler
// Feeds control points with random gaps, stalls the sample receiver at
// random and at least once for a long stretch, and steps the sample count
// through its extremes between phases. A scoreboard module checks every sample.
// ----------------------------------------------------------------------------
module tb_catmull_rom_curve_sampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The longest quiet stretch of a correct run is the long receiver hold
  // plus a full 64-sample segment; this is several times that.
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  // Give the block a comfortable margin after a point that only enters the
  // history, before touching the register or ending the run.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 24;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  crs_pkg::crs_in_t          in_data;
  logic                      out_valid;
  logic                      out_ready;
  crs_pkg::crs_out_t         out_data;
  logic                      cfg_we;
  logic [crs_pkg::CFG_W-1:0] cfg_wdata;

  int pending;
  int mismatches;
  int points_seen;
  int samples_seen;
  int count_writes;
  int idle_cycles;
  int hold_req;
  int hold_done;
  bit no_idle;

  always #5 clk = ~clk;

  catmull_rom_curve_sampler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // The scoreboard sits beside the block and sees the same pins.
  crs_sample_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .pending      (pending),
    .mismatches   (mismatches),
    .points_seen  (points_seen),
    .samples_seen (samples_seen)
  );

  // Watchdog: a correct run never goes this long without a transaction on
  // either channel, so reaching the limit means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles, %0d samples still due.",
               idle_cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap before the next point: mostly none or short, now and then long.
  function automatic int sender_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Coordinates lean on the edges of the range so every bit goes both ways.
  function automatic logic [crs_pkg::PT_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return crs_pkg::PT_W'($urandom_range(0, 1023));
  endfunction

  // Offer one control point and hold it until the block takes it. Valid is
  // left high on return, so a back-to-back point just replaces the payload.
  task automatic send_point(input logic [crs_pkg::PT_W-1:0] x,
                            input logic [crs_pkg::PT_W-1:0] y,
                            input logic nc);
    int               gap;
    crs_pkg::crs_in_t pt;
    gap = sender_gap();
    pt.point_x   = x;
    pt.point_y   = y;
    pt.new_curve = nc;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait until every expected sample has come out, let the block settle,
  // then write the sample count. The register is only touched while idle.
  task automatic write_count(input logic [crs_pkg::CFG_W-1:0] n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_writes++;
  endtask

  // Random traffic. Most of it is whole curves (a new_curve point followed by
  // several ordinary ones) so that segments really get closed; the rest is
  // short runs with random new_curve flags that break curves up early.
  task automatic run_curves(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(4, 10);
        for (int k = 0; k < len && sent < items; k++) begin
          send_point(pick_coord(), pick_coord(), k == 0);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len && sent < items; k++) begin
          send_point(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // Receiver: ready most of the time, with short and occasional long stalls.
  // When the stimulus asks for it, it also holds off for a long stretch so
  // that the output register fills and the sampler stops taking points.
  initial begin : receiver
    int stall;
    int r;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin : stimulus
    logic [crs_pkg::CFG_W-1:0] phase_counts [9];
    // Every input is known from time zero, with reset held low at the start.
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    no_idle      = 1'b0;
    hold_req     = 0;
    hold_done    = 0;
    count_writes = 0;
    idle_cycles  = 0;
    phase_counts = '{7'd3, 7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd17, 7'd5, 7'd40};
    phase_counts[8] = crs_pkg::CFG_W'($urandom_range(1, 64));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset count of 64 samples per segment.
    // A new curve on an empty history, then corner-to-corner zigzags that
    // swing every bit of both coordinates.
    send_point(10'd0, 10'd0, 1'b1);
    send_point(10'd1023, 10'd1023, 1'b0);
    send_point(10'd0, 10'd0, 1'b0);
    send_point(10'd1023, 10'd1023, 1'b0);
    send_point(10'd0, 10'd1023, 1'b0);
    // Restart while a full history is held, then again with only two points
    // held, so the partial curve is dropped before it closes a segment.
    send_point(10'd1023, 10'd0, 1'b1);
    send_point(10'd512, 10'd5, 1'b0);
    send_point(10'd5, 10'd512, 1'b1);
    send_point(10'd700, 10'd300, 1'b0);
    send_point(10'd300, 10'd700, 1'b0);
    send_point(10'd1023, 10'd0, 1'b0);
    send_point(10'd0, 10'd1023, 1'b0);

    // One sample per segment, then zero (treated as one), then counts above
    // the maximum, which clamp to 64.
    write_count(7'd1);
    send_point(10'd1023, 10'd1023, 1'b0);
    send_point(10'd0, 10'd0, 1'b0);
    write_count(7'd0);
    send_point(10'd1023, 10'd0, 1'b0);
    send_point(10'd0, 10'd1023, 1'b0);
    write_count(7'd127);
    send_point(10'd1023, 10'd1023, 1'b0);
    write_count(7'd65);
    send_point(10'd0, 10'd0, 1'b0);

    // Random phases, each at its own sample count. Odd phases run with no
    // idling on either side; a phase at a count of 64 starts with the long hold.
    for (int p = 0; p < 9; p++) begin
      write_count(phase_counts[p]);
      no_idle = p[0];
      if (phase_counts[p] == 7'd64) hold_req++;
      run_curves(PHASE_ITEMS);
    end

    // Drain: wait for every expected sample, then a settling margin so a
    // stray extra sample would still be caught.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d control points and %0d curve samples,", points_seen, samples_seen);
    $display("with %0d writes of the sample count including 0, 1, 64 and above 64.",
             count_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/crs_pkg.sv
design/crs_mac.sv
design/crs_tgen.sv
design/crs_seq.sv
design/catmull_rom_curve_sampler_top.sv
bench/crs_sample_checker.sv
bench/tb_catmull_rom_curve_sampler_top.sv
